// File: rtl/fxalu_pkg.sv
// shared types and command codes for the q24.8 fixed-point alu
`timescale 1ns / 1ps
package fxalu_pkg;

  typedef enum logic [3:0] {
    CmdAdd     = 4'd0,
    CmdSub     = 4'd1,
    CmdMul     = 4'd2,
    CmdDiv     = 4'd3,
    CmdGt      = 4'd4,
    CmdLt      = 4'd5,
    CmdGe      = 4'd6,
    CmdLe      = 4'd7,
    CmdEq      = 4'd8,
    CmdNe      = 4'd9,
    CmdMin     = 4'd10,
    CmdMax     = 4'd11,
    CmdInc     = 4'd12,
    CmdDec     = 4'd13,
    CmdFromInt = 4'd14,
    CmdToInt   = 4'd15
  } cmd_e;

  // which back-end unit carries out an item
  typedef enum logic [1:0] {
    UnitSimple = 2'd0,
    UnitMul    = 2'd1,
    UnitDiv    = 2'd2
  } unit_e;

endpackage

// File: rtl/fixed_point_alu_q24_8_top.sv
// top level of the q24.8 fixed-point alu
//
//  channel  | handshake   | payload
//  ---------+-------------+-----------------------------------------
//  input    | push / full | command_i, operand_a_i, operand_b_i
//  result   | empty / pop | result_value_o, compare_true_o,
//           |             | divide_by_zero_o
//
// one item per cycle for all commands except divide while the result queue
// has room; items pass front, execute and output registers. a divide with
// nonzero divisor holds the execute stage for the one-bit-per-cycle divider.
// reset clears all valid and queue state; payload registers are not reset.
// a full result queue stalls the execute pipe, which stalls the input side.
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_top #(
  parameter int FRAC_BITS  = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [3:0]                   command_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [DATA_WIDTH-1:0] result_value_o,
  output logic                         compare_true_o,
  output logic                         divide_by_zero_o
);

  logic                         f_valid, f_ready;
  fxalu_pkg::cmd_e              f_cmd;
  fxalu_pkg::unit_e             f_unit;
  logic signed [DATA_WIDTH-1:0] f_a, f_b;
  logic                         b_valid, b_ready;
  logic signed [DATA_WIDTH-1:0] b_res;
  logic                         b_cmp, b_dz;

  fxalu_front #(.DataWidth(DATA_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .command_i  (command_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .valid_o    (f_valid),
    .ready_i    (f_ready),
    .cmd_o      (f_cmd),
    .unit_o     (f_unit),
    .a_o        (f_a),
    .b_o        (f_b)
  );

  fxalu_back #(.DataWidth(DATA_WIDTH), .FracBits(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .cmd_i   (f_cmd),
    .unit_i  (f_unit),
    .a_i     (f_a),
    .b_i     (f_b),
    .valid_o (b_valid),
    .ready_i (b_ready),
    .result_o(b_res),
    .cmp_o   (b_cmp),
    .dz_o    (b_dz)
  );

  fxalu_outq #(.DataWidth(DATA_WIDTH)) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid),
    .ready_o (b_ready),
    .result_i(b_res),
    .cmp_i   (b_cmp),
    .dz_i    (b_dz),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_value_o),
    .cmp_o   (compare_true_o),
    .dz_o    (divide_by_zero_o)
  );

endmodule

// File: rtl/fxalu_front.sv
// front end: single-register input stage that classifies and forwards items
`timescale 1ns / 1ps
module fxalu_front #(
  parameter int DataWidth = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [3:0]                  command_i,
  input  logic signed [DataWidth-1:0] operand_a_i,
  input  logic signed [DataWidth-1:0] operand_b_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output fxalu_pkg::cmd_e             cmd_o,
  output fxalu_pkg::unit_e            unit_o,
  output logic signed [DataWidth-1:0] a_o,
  output logic signed [DataWidth-1:0] b_o
);

  logic                        valid_q, valid_d;
  fxalu_pkg::cmd_e             cmd_q;
  fxalu_pkg::unit_e            unit_q;
  logic signed [DataWidth-1:0] a_q, b_q;
  fxalu_pkg::unit_e            unit_c;
  logic                        load;

  always_comb begin
    unique case (fxalu_pkg::cmd_e'(command_i))
      fxalu_pkg::CmdMul: unit_c = fxalu_pkg::UnitMul;
      fxalu_pkg::CmdDiv: unit_c = fxalu_pkg::UnitDiv;
      default:           unit_c = fxalu_pkg::UnitSimple;
    endcase
  end

  assign full    = valid_q && !ready_i;
  assign load    = push && !full;
  assign valid_d = load ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q  <= fxalu_pkg::cmd_e'(command_i);
      unit_q <= unit_c;
      a_q    <= operand_a_i;
      b_q    <= operand_b_i;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;
  assign unit_o  = unit_q;
  assign a_o     = a_q;
  assign b_o     = b_q;

endmodule

// File: rtl/fxalu_div.sv
// iterative signed divider, one quotient bit per cycle, dividend a << frac
`timescale 1ns / 1ps
module fxalu_div #(
  parameter int DataWidth = 32,
  parameter int FracBits  = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [DataWidth-1:0] a_i,
  input  logic signed [DataWidth-1:0] b_i,
  output logic                        done_o,
  output logic [DataWidth-1:0]        quot_o
);

  localparam int NumW = DataWidth + FracBits;
  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q, done_q, neg_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] num_q;
  logic [DataWidth:0] rem_q, div_q;
  logic [DataWidth:0] rem_sh, rem_sub;
  logic [DataWidth-1:0] mag_a, mag_b;
  logic [NumW-1:0] qbits_q;

  assign mag_a   = a_i[DataWidth-1] ? DataWidth'(-a_i) : a_i;
  assign mag_b   = b_i[DataWidth-1] ? DataWidth'(-b_i) : b_i;
  assign rem_sh  = {rem_q[DataWidth-1:0], num_q[NumW-1]};
  assign rem_sub = rem_sh - div_q;

  // done stays high until the next start so a blocked consumer keeps the quotient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q   <= {mag_a, {FracBits{1'b0}}};
      div_q   <= {1'b0, mag_b};
      rem_q   <= '0;
      qbits_q <= '0;
      neg_q   <= a_i[DataWidth-1] ^ b_i[DataWidth-1];
    end else if (busy_q) begin
      num_q <= num_q << 1;
      if (!rem_sub[DataWidth]) begin
        rem_q   <= rem_sub;
        qbits_q <= {qbits_q[NumW-2:0], 1'b1};
      end else begin
        rem_q   <= rem_sh;
        qbits_q <= {qbits_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? DataWidth'(-qbits_q) : qbits_q[DataWidth-1:0];

endmodule

// File: rtl/fxalu_back.sv
// back end: two-stage execute pipe with one iterative divider
`timescale 1ns / 1ps
module fxalu_back #(
  parameter int DataWidth = 32,
  parameter int FracBits  = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  fxalu_pkg::cmd_e             cmd_i,
  input  fxalu_pkg::unit_e            unit_i,
  input  logic signed [DataWidth-1:0] a_i,
  input  logic signed [DataWidth-1:0] b_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic signed [DataWidth-1:0] result_o,
  output logic                        cmp_o,
  output logic                        dz_o
);

  localparam int ProdW = 2 * DataWidth;

  // stage 1: simple ops, or a registered product, or divider launch
  logic                        s1_valid_q;
  logic                        s1_mul_q, s1_div_q;
  logic signed [DataWidth-1:0] s1_res_q;
  logic                        s1_cmp_q, s1_dz_q;
  logic signed [ProdW-1:0]     s1_prod_q;
  logic                        s1_adv, take;
  logic                        div_done, div_start;
  logic [DataWidth-1:0]        div_quot;
  logic                        div_wait;
  logic signed [DataWidth-1:0] res_c;
  logic                        cmp_c, lt_ab, lt_ba;
  logic signed [ProdW-1:0]     prod_sh;
  logic signed [DataWidth-1:0] out_res;

  // output register
  logic                        o_valid_q;
  logic signed [DataWidth-1:0] o_res_q;
  logic                        o_cmp_q, o_dz_q;

  assign lt_ab = a_i < b_i;
  assign lt_ba = b_i < a_i;

  always_comb begin
    res_c = '0;
    cmp_c = 1'b0;
    case (cmd_i)
      fxalu_pkg::CmdAdd:     res_c = a_i + b_i;
      fxalu_pkg::CmdSub:     res_c = a_i - b_i;
      fxalu_pkg::CmdGt:      cmp_c = lt_ba;
      fxalu_pkg::CmdLt:      cmp_c = lt_ab;
      fxalu_pkg::CmdGe:      cmp_c = !lt_ab;
      fxalu_pkg::CmdLe:      cmp_c = !lt_ba;
      fxalu_pkg::CmdEq:      cmp_c = (a_i == b_i);
      fxalu_pkg::CmdNe:      cmp_c = (a_i != b_i);
      fxalu_pkg::CmdMin:     res_c = lt_ba ? b_i : a_i;
      fxalu_pkg::CmdMax:     res_c = lt_ab ? b_i : a_i;
      fxalu_pkg::CmdInc:     res_c = a_i + DataWidth'(1);
      fxalu_pkg::CmdDec:     res_c = a_i - DataWidth'(1);
      fxalu_pkg::CmdFromInt: res_c = a_i <<< FracBits;
      fxalu_pkg::CmdToInt:   res_c = a_i >>> FracBits;
      default: ;
    endcase
  end

  // stage 1 holds while divider runs or output is blocked
  assign div_wait = s1_valid_q && s1_div_q && !s1_dz_q && !div_done;
  assign s1_adv   = !s1_valid_q || ((!o_valid_q || ready_i) && !div_wait);
  assign take     = valid_i && s1_adv;
  assign ready_o  = s1_adv;
  assign div_start = take && unit_i == fxalu_pkg::UnitDiv && b_i != '0;

  fxalu_div #(
    .DataWidth(DataWidth),
    .FracBits (FracBits)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .a_i    (a_i),
    .b_i    (b_i),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= valid_i;
      end
      if (s1_adv && s1_valid_q) begin
        o_valid_q <= 1'b1;
      end else if (ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // signed 32x32 product, full width
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_mul_q  <= unit_i == fxalu_pkg::UnitMul;
      s1_div_q  <= unit_i == fxalu_pkg::UnitDiv;
      s1_res_q  <= res_c;
      s1_cmp_q  <= cmp_c;
      s1_dz_q   <= unit_i == fxalu_pkg::UnitDiv && b_i == '0;
      s1_prod_q <= a_i * b_i;
    end
  end

  assign prod_sh = s1_prod_q >>> FracBits;

  always_comb begin
    if (s1_mul_q) begin
      out_res = prod_sh[DataWidth-1:0];
    end else if (s1_div_q) begin
      out_res = s1_dz_q ? '0 : div_quot;
    end else begin
      out_res = s1_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      o_res_q <= out_res;
      o_cmp_q <= s1_cmp_q && !s1_mul_q && !s1_div_q;
      o_dz_q  <= s1_div_q && s1_dz_q;
    end
  end

  assign valid_o  = o_valid_q;
  assign result_o = o_res_q;
  assign cmp_o    = o_cmp_q;
  assign dz_o     = o_dz_q;

endmodule

// File: rtl/fxalu_outq.sv
// small result queue that drives the empty/pop side
`timescale 1ns / 1ps
module fxalu_outq #(
  parameter int DataWidth = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic signed [DataWidth-1:0] result_i,
  input  logic                        cmp_i,
  input  logic                        dz_i,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [DataWidth-1:0] result_o,
  output logic                        cmp_o,
  output logic                        dz_o
);

  localparam int EntW = DataWidth + 2;

  logic [EntW-1:0] mem_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            wr, rd;
  logic [EntW-1:0] head;

  assign ready_o = cnt_q != 2'd2;
  assign wr      = valid_i && ready_o;
  assign empty   = cnt_q == 2'd0;
  assign rd      = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= {result_i, cmp_i, dz_i};
    end
  end

  assign head     = mem_q[rp_q];
  assign result_o = head[EntW-1:2];
  assign cmp_o    = head[1];
  assign dz_o     = head[0];

endmodule

// File: dv/tb_fixed_point_alu_q24_8_top.sv
// self-checking testbench for the q24.8 fixed-point alu
`timescale 1ns / 1ps
module tb_fixed_point_alu_q24_8_top;

  typedef struct packed {
    logic signed [31:0] value;
    logic               cmp;
    logic               dz;
  } alu_res_t;

  class alu_scoreboard;
    alu_res_t pending_q[$];
    int       errors;

    function alu_res_t compute(fxalu_pkg::cmd_e cmd, logic signed [31:0] a,
                               logic signed [31:0] b);
      alu_res_t r;
      logic signed [63:0] prod;
      logic signed [63:0] num;
      logic signed [63:0] quo;
      r = '0;
      case (cmd)
        fxalu_pkg::CmdAdd: r.value = a + b;
        fxalu_pkg::CmdSub: r.value = a - b;
        fxalu_pkg::CmdMul: begin
          prod = 64'(a) * 64'(b);
          r.value = 32'(prod >>> 8);
        end
        fxalu_pkg::CmdDiv: begin
          if (b == 0) begin
            r.dz = 1'b1;
          end else begin
            num = 64'(a) <<< 8;
            quo = num / 64'(b);
            r.value = 32'(quo);
          end
        end
        fxalu_pkg::CmdGt: r.cmp = a > b;
        fxalu_pkg::CmdLt: r.cmp = a < b;
        fxalu_pkg::CmdGe: r.cmp = a >= b;
        fxalu_pkg::CmdLe: r.cmp = a <= b;
        fxalu_pkg::CmdEq: r.cmp = a == b;
        fxalu_pkg::CmdNe: r.cmp = a != b;
        fxalu_pkg::CmdMin: r.value = (b < a) ? b : a;
        fxalu_pkg::CmdMax: r.value = (a < b) ? b : a;
        fxalu_pkg::CmdInc: r.value = a + 1;
        fxalu_pkg::CmdDec: r.value = a - 1;
        fxalu_pkg::CmdFromInt: r.value = a <<< 8;
        default: r.value = a >>> 8;
      endcase
      return r;
    endfunction

    function void note_input(fxalu_pkg::cmd_e cmd, logic signed [31:0] a,
                             logic signed [31:0] b);
      pending_q.push_back(compute(cmd, a, b));
    endfunction

    function void check_result(alu_res_t got);
      alu_res_t exp;
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing expected: value %0d", got.value);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.value !== exp.value) begin
        $error("result_value expected %0d actual %0d", exp.value, got.value);
        errors++;
      end
      if (got.cmp !== exp.cmp) begin
        $error("compare_true expected %0b actual %0b", exp.cmp, got.cmp);
        errors++;
      end
      if (got.dz !== exp.dz) begin
        $error("divide_by_zero expected %0b actual %0b", exp.dz, got.dz);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [3:0] command_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic full, empty, compare_true_o, divide_by_zero_o;
  logic signed [31:0] result_value_o;

  alu_scoreboard sb = new();
  longint cycles = 0;
  bit stim_done = 0;

  fixed_point_alu_q24_8_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .command_i(command_i), .operand_a_i(operand_a_i), .operand_b_i(operand_b_i),
    .empty(empty), .pop(pop), .result_value_o(result_value_o),
    .compare_true_o(compare_true_o), .divide_by_zero_o(divide_by_zero_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 1024)) - 512);
      3: return '0;
      4: return 32'($urandom_range(0, 255)) << $urandom_range(0, 23);
      default: return $urandom();
    endcase
  endfunction

  // drive one item and hold it until the transfer happens
  task automatic send_item(fxalu_pkg::cmd_e cmd, logic [31:0] a, logic [31:0] b);
    push <= 1'b1;
    command_i <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (full);
    sb.note_input(cmd, a, b);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  // sink side
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      g = stim_done ? 0 : gap_len();
      pop <= (g == 0);
      if (g != 0) begin
        repeat (g - 1) @(negedge clk_i);
        @(negedge clk_i);
        pop <= 1'b1;
      end
      @(posedge clk_i);
      if (pop && !empty) sb.check_result({result_value_o, compare_true_o, divide_by_zero_o});
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    fxalu_pkg::cmd_e cmd;
    logic [31:0] a, b;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corners: every command, extreme operands, zero divisor, overflow
    for (int c = 0; c < 16; c++) begin
      send_item(fxalu_pkg::cmd_e'(c), 32'h0000_0300, 32'hffff_fe80);
    end
    send_item(fxalu_pkg::CmdDiv, 32'h8000_0000, 32'h0000_0001);
    send_item(fxalu_pkg::CmdDiv, 32'h1234_5678, 32'h0);
    send_item(fxalu_pkg::CmdMul, 32'h8000_0000, 32'h8000_0000);
    send_item(fxalu_pkg::CmdMul, 32'h7fff_ffff, 32'h8000_0000);
    send_item(fxalu_pkg::CmdMin, 32'h0000_0100, 32'h0000_0100);
    send_item(fxalu_pkg::CmdMax, 32'h8000_0000, 32'h7fff_ffff);
    send_item(fxalu_pkg::CmdInc, 32'h7fff_ffff, 32'hffff_ffff);
    send_item(fxalu_pkg::CmdDec, 32'h8000_0000, 32'h0);
    send_item(fxalu_pkg::CmdToInt, 32'hffff_ffff, 32'h0);
    drain();

    for (int i = 0; i < 450; i++) begin
      cmd = fxalu_pkg::cmd_e'($urandom_range(0, 15));
      // keep slow divides a minority
      if (cmd == fxalu_pkg::CmdDiv && $urandom_range(0, 2) != 0) cmd = fxalu_pkg::CmdAdd;
      a = rand_operand();
      b = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? a : '0) : rand_operand();
      idle_sender((i < 60 || (i > 250 && i < 300)) ? 0 : gap_len());
      send_item(cmd, a, b);
      if (i == 200) drain();
    end
    drain();
    stim_done = 1;
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
